@@ src/rle_pattern_decoder_macros.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef RLE_PATTERN_DECODER_MACROS_SVH
`define RLE_PATTERN_DECODER_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define RPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpd assertion failed");

// Next-cycle implication.
`define RPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpd assertion failed");

`endif

@@ src/rpd_pkg.sv @@
// Shared types, constants and codes of the run-length pattern decoder.
package rpd_pkg;

  localparam int PATTERN_DEPTH = 256;
  localparam int LENGTH_BITS   = 29;
  localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
  localparam int IDX_W         = 8;
  localparam int STATUS_W      = 3;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_BYTE   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_END    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZLEN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IDLE   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ZPAT   = 3'd6;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic       last_byte;
  } rpd_in_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic [STATUS_W-1:0] status;
  } rpd_out_t;

  // Pattern store port: one write and one registered read per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } rpd_ram_req_t;

endpackage

@@ src/rle_pattern_decoder.sv @@
// An accepted input is held in the input register; its result goes to the result register.
// Throughput: one transaction per cycle while out_stall is low; each gives exactly one result.
// The single pattern-store read port is re-aimed every cycle, so replay ticks run back to back.
// Reset (rst_n low, synchronous) clears both registers' valid flags and the decoder state;
// the pattern store is not cleared and reads as undefined until written.
`include "rle_pattern_decoder_macros.svh"
module rle_pattern_decoder
  import rpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  rpd_in_t  in_item,
  output logic     in_stall,
  output logic     out_valid,
  output rpd_out_t out_item,
  input  logic     out_stall
);

  logic     in_valid_r;
  rpd_in_t  in_item_r;
  logic     out_valid_r;
  rpd_out_t out_item_r;
  rpd_out_t result;
  logic     advance;

  // the held transaction moves on when the result register is free
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  rpd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // input stalls only behind a full, stalled result register
  `RPD_ASSERT_NOW(a_stall_cause, in_stall, out_valid_r && out_stall)
  // a processed transaction always lands in the result register
  `RPD_ASSERT_NEXT(a_advance_lands, advance, out_valid_r)

endmodule

@@ src/rpd_pattern_ram.sv @@
// Pattern store: single write port, registered read with write forwarding.
module rpd_pattern_ram
  import rpd_pkg::*;
(
  input  logic         clk,
  input  rpd_ram_req_t req,
  output logic [7:0]   rd_data
);

  logic [7:0] mem [PATTERN_DEPTH];
  logic [7:0] rd_data_r;

  // Write, and read the entry the next transaction will use
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.we && (req.waddr == req.raddr)) begin
      rd_data_r <= req.wdata;
    end else begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/rpd_core.sv @@
// Decoder state machine: record parsing, literal pass-through and pattern replay.
`include "rle_pattern_decoder_macros.svh"
module rpd_core
  import rpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  rpd_in_t  item,
  output rpd_out_t result
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_PATLEN  = 3'd2;
  localparam logic [2:0] PH_PATTERN = 3'd3;
  localparam logic [2:0] PH_LITERAL = 3'd4;
  localparam logic [2:0] PH_REPEAT  = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;

  // header flag bits
  localparam int FL_REPEAT = 0;
  localparam int FL_HASPAT = 1;
  localparam int FL_LONG   = 2;

  logic [2:0]             phase_r, phase_nxt;
  logic [2:0]             flags_r, flags_nxt;
  logic [LENGTH_BITS-1:0] run_len_r, run_len_nxt;
  logic [1:0]             len_left_r, len_left_nxt;
  logic [IDX_W-1:0]       pat_len_r, pat_len_nxt;
  logic [IDX_W-1:0]       pat_idx_r, pat_idx_nxt;
  logic [LENGTH_BITS-1:0] reps_r, reps_nxt;

  rpd_ram_req_t ram_req;
  logic [7:0]   rd_data;

  rpd_pattern_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // Next state and result for the transaction in the input register
  always_comb begin
    logic [7:0]             b;
    logic [LENGTH_BITS-1:0] len_val;
    logic                   len_done;
    logic [IDX_W-1:0]       idx_inc;
    b           = item.data_byte;
    len_val     = '0;
    len_done    = 1'b0;
    idx_inc     = pat_idx_r + IDX_W'(1);
    phase_nxt   = phase_r;
    flags_nxt   = flags_r;
    run_len_nxt = run_len_r;
    len_left_nxt = len_left_r;
    pat_len_nxt = pat_len_r;
    pat_idx_nxt = pat_idx_r;
    reps_nxt    = reps_r;
    result.out_byte = 8'd0;
    result.status   = ST_ACCEPT;
    ram_req.we    = 1'b0;
    ram_req.waddr = pat_idx_r[ADDR_W-1:0];
    ram_req.wdata = b;

    if (step) begin
      if (item.opcode == OP_TICK) begin
        if (phase_r != PH_REPEAT) begin
          result.status = ST_IDLE;
        end else begin
          result.out_byte = rd_data;
          result.status   = ST_BYTE;
          pat_idx_nxt     = idx_inc;
          if (idx_inc >= pat_len_r) begin
            pat_idx_nxt = '0;
            reps_nxt    = reps_r - LENGTH_BITS'(1);
            if (reps_nxt == '0) begin
              phase_nxt = PH_HEADER;
            end
          end
        end
      end else if (phase_r == PH_REPEAT) begin
        result.status = ST_BUSY;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (b == 8'd0) begin
              result.status = ST_END;
              phase_nxt     = PH_SKIP;
            end else begin
              flags_nxt[FL_REPEAT] = b[7];
              flags_nxt[FL_HASPAT] = b[6];
              flags_nxt[FL_LONG]   = b[5];
              pat_len_nxt = IDX_W'(1);
              pat_idx_nxt = '0;
              if (b[5]) begin
                run_len_nxt  = LENGTH_BITS'(b[4:0]);
                len_left_nxt = 2'd3;
              end else begin
                run_len_nxt  = LENGTH_BITS'(b[3:0]);
                len_left_nxt = b[4] ? 2'd1 : 2'd0;
              end
              if (len_left_nxt != 2'd0) begin
                phase_nxt = PH_LENGTH;
              end else begin
                len_done = 1'b1;
                len_val  = run_len_nxt;
              end
            end
          end
          PH_LENGTH: begin
            run_len_nxt  = LENGTH_BITS'({run_len_r, b});
            len_left_nxt = len_left_r - 2'd1;
            if (len_left_nxt == 2'd0) begin
              len_done = 1'b1;
              len_val  = run_len_nxt;
            end
          end
          PH_PATLEN: begin
            if (flags_r[FL_REPEAT] && (b == 8'd0)) begin
              result.status = ST_ZPAT;
              phase_nxt     = PH_SKIP;
            end else begin
              if (flags_r[FL_REPEAT]) begin
                pat_len_nxt = b;
              end
              pat_idx_nxt = '0;
              phase_nxt   = flags_r[FL_REPEAT] ? PH_PATTERN : PH_LITERAL;
            end
          end
          PH_PATTERN: begin
            ram_req.we  = 1'b1;
            pat_idx_nxt = idx_inc;
            if (idx_inc >= pat_len_r) begin
              pat_idx_nxt = '0;
              reps_nxt    = run_len_r;
              phase_nxt   = PH_REPEAT;
            end
          end
          PH_LITERAL: begin
            result.out_byte = b;
            result.status   = ST_BYTE;
            run_len_nxt     = run_len_r - LENGTH_BITS'(1);
            if (run_len_nxt == '0) begin
              phase_nxt = PH_HEADER;
            end
          end
          default: begin
            phase_nxt = PH_SKIP;
          end
        endcase

        // length field complete: check for zero and go to the pattern length or the body
        if (len_done) begin
          if (len_val == '0) begin
            result.status = ST_ZLEN;
            phase_nxt     = PH_SKIP;
          end else if (flags_nxt[FL_HASPAT]) begin
            phase_nxt = PH_PATLEN;
          end else begin
            pat_idx_nxt = '0;
            phase_nxt   = flags_nxt[FL_REPEAT] ? PH_PATTERN : PH_LITERAL;
          end
        end

        // frame end returns to header wait unless a run is ready to drain
        if (item.last_byte && (phase_nxt != PH_REPEAT)) begin
          phase_nxt = PH_HEADER;
        end
      end
    end

    // keep the read data lined up with the index of the next transaction
    ram_req.raddr = pat_idx_nxt[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      flags_r    <= '0;
      run_len_r  <= '0;
      len_left_r <= '0;
      pat_len_r  <= IDX_W'(1);
      pat_idx_r  <= '0;
      reps_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      flags_r    <= flags_nxt;
      run_len_r  <= run_len_nxt;
      len_left_r <= len_left_nxt;
      pat_len_r  <= pat_len_nxt;
      pat_idx_r  <= pat_idx_nxt;
      reps_r     <= reps_nxt;
    end
  end

  // a replay run always has repeats outstanding
  `RPD_ASSERT_NOW(a_repeat_has_count, phase_r == PH_REPEAT, reps_r != '0)
  // the pattern length never reaches zero, so replay index always wraps
  `RPD_ASSERT_NOW(a_patlen_nonzero, phase_r == PH_REPEAT, pat_len_r != '0)
  // stores happen only while capturing a pattern
  `RPD_ASSERT_NOW(a_write_in_pattern, ram_req.we, step && (phase_r == PH_PATTERN))

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the run-length pattern decoder: random stream, item predictor.
module tb import rpd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 10;

  // Header byte fields
  localparam logic [7:0] HDR_REPEAT = 8'h80;
  localparam logic [7:0] HDR_PATLEN = 8'h40;
  localparam logic [7:0] HDR_LONG   = 8'h20;
  localparam logic [7:0] HDR_MID    = 8'h10;
  localparam logic [7:0] END_MARKER = 8'h00;

  typedef enum logic [2:0] {
    PH_HEADER, PH_LENGTH, PH_PATLEN, PH_PATTERN, PH_LITERAL, PH_REPEAT, PH_SKIP
  } dec_phase_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  rpd_in_t  in_item = '0;
  logic     in_stall;
  logic     out_valid;
  rpd_out_t out_item;
  logic     out_stall = 1'b0;

  rle_pattern_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_item (out_item),
    .out_stall(out_stall)
  );

  always #5 clk = ~clk;

  // Decoder state as predicted
  dec_phase_t             m_phase;
  logic                   m_repeat;
  logic                   m_haspat;
  logic [LENGTH_BITS-1:0] m_run_len;
  logic [LENGTH_BITS-1:0] m_reps_left;
  logic [1:0]             m_len_left;
  logic [7:0]             m_pat_len;
  logic [7:0]             m_pat_idx;
  logic [7:0]             m_store [PATTERN_DEPTH];

  rpd_in_t    pending_items [$];
  rpd_out_t   expected_results [$];
  logic [7:0] rec_bytes [$];

  rpd_out_t want;
  int       errors = 0;
  int       taken_count = 0;
  int       cycle_count = 0;
  logic     in_took = 1'b0;
  int       gap_left = 0;
  int       burst_left = 0;
  int       stall_left = 0;
  logic     stall_on = 1'b0;
  logic     stall_pick;
  int       hold_left = 0;
  logic     hold_done = 1'b0;

  function automatic void enter_body();
    m_pat_idx = '0;
    m_phase = m_repeat ? PH_PATTERN : PH_LITERAL;
  endfunction

  // Length field complete: zero length aborts the record
  function automatic logic [STATUS_W-1:0] close_length();
    if (m_run_len == '0) begin
      m_phase = PH_SKIP;
      return ST_ZLEN;
    end
    if (m_haspat) m_phase = PH_PATLEN;
    else enter_body();
    return ST_ACCEPT;
  endfunction

  // One transaction in, one result out; updates the predicted state
  function automatic rpd_out_t decode_step(rpd_in_t it);
    rpd_out_t   res;
    logic [7:0] b;
    b = it.data_byte;
    res.out_byte = 8'h00;
    res.status = ST_ACCEPT;
    if (it.opcode == OP_TICK) begin
      if (m_phase != PH_REPEAT) begin
        res.status = ST_IDLE;
      end else begin
        res.out_byte = m_store[m_pat_idx];
        res.status = ST_BYTE;
        m_pat_idx = m_pat_idx + 8'd1;
        if (m_pat_idx >= m_pat_len) begin
          m_pat_idx = '0;
          m_reps_left = m_reps_left - LENGTH_BITS'(1);
          if (m_reps_left == '0) m_phase = PH_HEADER;
        end
      end
    end else if (m_phase == PH_REPEAT) begin
      res.status = ST_BUSY;
    end else begin
      case (m_phase)
        PH_HEADER: begin
          if (b == END_MARKER) begin
            res.status = ST_END;
            m_phase = PH_SKIP;
          end else begin
            m_repeat = |(b & HDR_REPEAT);
            m_haspat = |(b & HDR_PATLEN);
            m_pat_len = 8'd1;
            m_pat_idx = '0;
            if (|(b & HDR_LONG)) begin
              m_run_len = LENGTH_BITS'(b[4:0]);
              m_len_left = 2'd3;
            end else begin
              m_run_len = LENGTH_BITS'(b[3:0]);
              m_len_left = |(b & HDR_MID) ? 2'd1 : 2'd0;
            end
            if (m_len_left != 2'd0) m_phase = PH_LENGTH;
            else res.status = close_length();
          end
        end
        PH_LENGTH: begin
          m_run_len = {m_run_len[LENGTH_BITS-9:0], b};
          m_len_left = m_len_left - 2'd1;
          if (m_len_left == 2'd0) res.status = close_length();
        end
        PH_PATLEN: begin
          // literal records take the byte and ignore it
          if (m_repeat && b == 8'h00) begin
            res.status = ST_ZPAT;
            m_phase = PH_SKIP;
          end else begin
            if (m_repeat) m_pat_len = b;
            enter_body();
          end
        end
        PH_PATTERN: begin
          m_store[m_pat_idx] = b;
          m_pat_idx = m_pat_idx + 8'd1;
          if (m_pat_idx >= m_pat_len) begin
            m_pat_idx = '0;
            m_reps_left = m_run_len;
            m_phase = PH_REPEAT;
          end
        end
        PH_LITERAL: begin
          res.out_byte = b;
          res.status = ST_BYTE;
          m_run_len = m_run_len - LENGTH_BITS'(1);
          if (m_run_len == '0) m_phase = PH_HEADER;
        end
        default: m_phase = PH_SKIP;
      endcase
      if (it.last_byte && m_phase != PH_REPEAT) m_phase = PH_HEADER;
    end
    return res;
  endfunction

  function automatic rpd_in_t mk_item(logic op, logic [7:0] b, logic last);
    rpd_in_t it;
    it.opcode = op;
    it.data_byte = b;
    it.last_byte = last;
    return it;
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic last);
    pending_items.push_back(mk_item(OP_BYTE, b, last));
  endtask

  task automatic add_tick();
    pending_items.push_back(mk_item(OP_TICK, 8'($urandom), 1'($urandom)));
  endtask

  // Header plus length bytes, in one of the forms that can hold len
  task automatic put_length(input logic [7:0] flags, input logic [28:0] len);
    int form;
    form = $urandom_range(0, 2);
    if (len < 16 && form == 0) begin
      rec_bytes.push_back(flags | len[7:0]);
    end else if (len < 4096 && form != 2) begin
      rec_bytes.push_back(flags | HDR_MID | {4'h0, len[11:8]});
      rec_bytes.push_back(len[7:0]);
    end else begin
      rec_bytes.push_back(flags | HDR_LONG | {3'b000, len[28:24]});
      rec_bytes.push_back(len[23:16]);
      rec_bytes.push_back(len[15:8]);
      rec_bytes.push_back(len[7:0]);
    end
  endtask

  // Send the record; a cut ends it early with last_byte set
  task automatic flush_record(input int cut_at, input logic last_end);
    int n;
    int i;
    n = rec_bytes.size();
    for (i = 0; i < n; i++) begin
      if (cut_at < 0 || i <= cut_at)
        add_byte(rec_bytes[i], (i == cut_at) || (last_end && i == n - 1));
    end
    rec_bytes.delete();
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Stimulus
  initial begin
    int          kind;
    int          reps;
    int          plen;
    int          body;
    int          n;
    int          cut_at;
    bit          cut;
    logic [7:0]  flags;
    logic [28:0] len;

    m_phase = PH_HEADER;
    m_repeat = 1'b0;
    m_haspat = 1'b0;
    m_run_len = '0;
    m_reps_left = '0;
    m_len_left = '0;
    m_pat_len = 8'd1;
    m_pat_idx = '0;

    // tick with no run active
    add_tick();
    // short literal, byte extremes
    add_byte(8'h03, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'hFF, 1'b0);
    add_byte(8'hA5, 1'b0);
    // literal with a pattern-length byte that is ignored
    add_byte(HDR_PATLEN | 8'h02, 1'b0); add_byte(8'h07, 1'b0);
    add_byte(8'h11, 1'b0); add_byte(8'h22, 1'b0);
    // two-byte pattern repeated twice, a byte refused mid-run
    add_byte(HDR_REPEAT | HDR_PATLEN | 8'h02, 1'b0); add_byte(8'h02, 1'b0);
    add_byte(8'h01, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'h33, 1'b1);
    repeat (4) add_tick();
    // zero length, then skip to last
    add_byte(HDR_REPEAT, 1'b0); add_byte(8'h12, 1'b1);
    // zero pattern length
    add_byte(HDR_REPEAT | HDR_PATLEN | 8'h01, 1'b0); add_byte(8'h00, 1'b1);
    // end marker
    add_byte(END_MARKER, 1'b0); add_byte(8'hFF, 1'b1);
    // largest 29-bit length, cut short by last byte
    add_byte(8'h3F, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0); add_byte(8'h77, 1'b1);

    n = pending_items.size() + RANDOM_ITEMS;
    while (pending_items.size() < n) begin
      kind = $urandom_range(0, 99);
      cut = ($urandom_range(0, 9) == 0);
      if (kind < 38) begin
        // literal record
        flags = ($urandom_range(0, 3) == 0) ? HDR_PATLEN : 8'h00;
        if (cut) len = $urandom_range(0, 1) ? 29'($urandom) : 29'($urandom_range(1, 300));
        else if ($urandom_range(0, 24) == 0) len = 29'($urandom_range(16, 60));
        else len = 29'($urandom_range(1, 10));
        if (len == 0) len = 1;
        put_length(flags, len);
        if (flags != 8'h00) rec_bytes.push_back(8'($urandom));
        body = (cut && len > 8) ? 8 : int'(len);
        repeat (body) rec_bytes.push_back(8'($urandom));
        cut_at = cut ? $urandom_range(0, rec_bytes.size() - 2) : -1;
        flush_record(cut_at, $urandom_range(0, 2) == 0);
      end else if (kind < 76) begin
        // repeat record, then the ticks that drain it unless it was cut
        flags = HDR_REPEAT | (($urandom_range(0, 9) < 7) ? HDR_PATLEN : 8'h00);
        if (flags & HDR_PATLEN)
          plen = ($urandom_range(0, 39) == 0) ? $urandom_range(20, 255) : $urandom_range(1, 6);
        else plen = 1;
        reps = (plen > 6) ? 1 : $urandom_range(1, 5);
        len = (cut && $urandom_range(0, 1)) ? 29'($urandom) : 29'(reps);
        if (len == 0) len = 1;
        put_length(flags, len);
        if (flags & HDR_PATLEN) rec_bytes.push_back(8'(plen));
        body = (cut && plen > 8) ? 8 : plen;
        repeat (body) rec_bytes.push_back(8'($urandom));
        cut_at = cut ? $urandom_range(0, rec_bytes.size() - 2) : -1;
        flush_record(cut_at, $urandom_range(0, 2) == 0);
        if (!cut) begin
          repeat (reps * plen) begin
            if ($urandom_range(0, 19) == 0) add_byte(8'($urandom), 1'($urandom));
            add_tick();
          end
          if ($urandom_range(0, 7) == 0) add_tick();
        end
      end else if (kind < 82) begin
        // end marker and discarded tail
        rec_bytes.push_back(END_MARKER);
        repeat ($urandom_range(0, 3)) rec_bytes.push_back(8'($urandom));
        flush_record(-1, 1'b1);
      end else if (kind < 88) begin
        // zero length in any form
        flags = {2'($urandom), 6'b000000};
        put_length(flags, '0);
        repeat ($urandom_range(0, 2)) rec_bytes.push_back(8'($urandom));
        flush_record(-1, 1'b1);
      end else if (kind < 92) begin
        // zero pattern length
        put_length(HDR_REPEAT | HDR_PATLEN, 29'($urandom_range(1, 5)));
        rec_bytes.push_back(8'h00);
        repeat ($urandom_range(0, 2)) rec_bytes.push_back(8'($urandom));
        flush_record(-1, 1'b1);
      end else if (kind < 96) begin
        repeat ($urandom_range(1, 3)) add_tick();
      end else begin
        // noise without repeat headers, closed by last
        repeat ($urandom_range(1, 4)) rec_bytes.push_back({1'b0, 7'($urandom)});
        flush_record(-1, 1'b1);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // Driver: next transaction after acceptance, with random gaps and gap-free bursts
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left <= burst_left - 1;
        end else begin
          gap_left <= gap_len();
          if ($urandom_range(0, 49) == 0) burst_left <= $urandom_range(30, 80);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps going
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && taken_count >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall <= stall_on;
        stall_left <= stall_left - 1;
      end else begin
        stall_pick = ($urandom_range(0, 99) < 35);
        stall_on <= stall_pick;
        out_stall <= stall_pick;
        if (stall_pick) stall_left <= gap_len() + 1;
        else if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(30, 100);
        else stall_left <= $urandom_range(1, 8);
      end
    end
  end

  // Monitor: check results, predict accepted transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result out_byte %02h status %0d", $time,
                   out_item.out_byte, out_item.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h", $time,
                     want.out_byte, out_item.out_byte);
            errors++;
          end
          if (out_item.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_item.status);
            errors++;
          end
        end
      end
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_results.push_back(decode_step(in_item));
        taken_count <= taken_count + 1;
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule

@@ sim.f @@
+incdir+src
src/rpd_pkg.sv
src/rpd_pattern_ram.sv
src/rpd_core.sv
src/rle_pattern_decoder.sv
sim/tb.sv
